// ===== rtl/core/bcd_pkg.sv =====
// Shared types and constants for the Bray-Curtis distance block.
`timescale 1ns / 1ps
`default_nettype none

package bcd_pkg;

  // Default widths handed to the top level parameters
  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 16;

  // Fixed field and accumulator widths
  localparam int TOTAL_W  = 48;
  localparam int DIST_W   = 17;
  localparam int STATUS_W = 2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                acc_en;
    logic                load;
    logic                step;
    logic                first_step;
    logic                emit;
    logic [STATUS_W-1:0] status;
  } bcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic den_zero;
  } bcd_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcd_dp.sv =====
// Datapath: saturating accumulators, restoring fraction divider, result registers.
`timescale 1ns / 1ps
`default_nettype none

module bcd_dp #(
  parameter int COUNT_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [COUNT_BITS-1:0]         count_a,
  input  wire logic [COUNT_BITS-1:0]         count_b,
  input  wire bcd_pkg::bcd_cmd_t             cmd,
  output bcd_pkg::bcd_stat_t                 stat,
  output logic                               out_valid,
  output logic [bcd_pkg::DIST_W-1:0]         out_distance,
  output logic [bcd_pkg::STATUS_W-1:0]       out_status
);
  import bcd_pkg::*;

  localparam int REM_W = TOTAL_W + 2;
  localparam int DEN_W = TOTAL_W + 1;
  localparam int QUO_W = FRACTION_BITS + 1;
  localparam logic [QUO_W-1:0] ONE_FIXED = QUO_W'(1) << FRACTION_BITS;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Add with clamp at the all-ones total
  function automatic logic [TOTAL_W-1:0] sat_add(
    input logic [TOTAL_W-1:0] acc,
    input logic [TOTAL_W-1:0] v
  );
    logic [TOTAL_W:0] s;
    s = {1'b0, acc} + {1'b0, v};
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

  logic [TOTAL_W-1:0]  diff_r, diff_nxt;
  logic [TOTAL_W-1:0]  first_r, first_nxt;
  logic [TOTAL_W-1:0]  second_r, second_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [QUO_W-1:0]    quo_r, quo_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                valid_r, valid_nxt;

  logic [COUNT_BITS-1:0] abs_diff;
  logic [REM_W-1:0]      rem_shift;
  logic                  fits;
  logic [QUO_W-1:0]      quo_capped;

  // Absolute difference of the pair
  assign abs_diff = (count_a > count_b) ? (count_a - count_b) : (count_b - count_a);

  // One restoring division step: shift (except on the first), compare, subtract
  assign rem_shift  = cmd.first_step ? rem_r : (rem_r << 1);
  assign fits       = (rem_shift >= REM_W'(den_r));
  assign quo_capped = (quo_r > ONE_FIXED) ? ONE_FIXED : quo_r;

  assign stat.den_zero = (den_r == '0);

  // Next-state logic for totals, divider and result
  always_comb begin
    diff_nxt   = diff_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    quo_nxt    = quo_r;
    dist_nxt   = dist_r;
    status_nxt = status_r;
    valid_nxt  = cmd.emit;

    if (cmd.acc_en) begin
      diff_nxt   = sat_add(diff_r, TOTAL_W'(abs_diff));
      first_nxt  = sat_add(first_r, TOTAL_W'(count_a));
      second_nxt = sat_add(second_r, TOTAL_W'(count_b));
    end

    if (cmd.load) begin
      den_nxt    = {1'b0, first_r} + {1'b0, second_r};
      rem_nxt    = REM_W'(diff_r);
      quo_nxt    = '0;
      diff_nxt   = '0;
      first_nxt  = '0;
      second_nxt = '0;
    end

    if (cmd.step) begin
      rem_nxt = fits ? (rem_shift - REM_W'(den_r)) : rem_shift;
      quo_nxt = {quo_r[QUO_W-2:0], fits};
    end

    if (cmd.emit) begin
      status_nxt = cmd.status;
      dist_nxt   = (cmd.status == ST_OK) ? DIST_W'(quo_capped) : '0;
    end
  end

  // Hold accumulators and result strobe under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diff_r   <= '0;
      first_r  <= '0;
      second_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      diff_r   <= diff_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Divider and result payload
  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    den_r    <= den_nxt;
    quo_r    <= quo_nxt;
    dist_r   <= dist_nxt;
    status_r <= status_nxt;
  end

  assign out_valid    = valid_r;
  assign out_distance = dist_r;
  assign out_status   = status_r;

endmodule

`default_nettype wire

// ===== rtl/core/bcd_ctrl.sv =====
// Controller: accepts items, sequences the load, divide steps and result strobe.
`timescale 1ns / 1ps
`default_nettype none

module bcd_ctrl #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               end_a,
  input  wire logic               end_b,
  input  wire bcd_pkg::bcd_stat_t stat,
  output bcd_pkg::bcd_cmd_t       cmd,
  output logic                    busy
);
  import bcd_pkg::*;

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FRACTION_BITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic                mism_r, mism_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  // Decode state into datapath commands
  always_comb begin
    state_nxt      = state_r;
    mism_nxt       = mism_r;
    cnt_nxt        = cnt_r;
    status_nxt     = status_r;
    cmd            = '0;
    cmd.status     = status_r;

    unique case (state_r)
      S_IDLE: begin
        cmd.acc_en = start;
        if (start && (end_a || end_b)) begin
          mism_nxt  = end_a ^ end_b;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        priority if (mism_r) begin
          status_nxt = ST_MISMATCH;
          state_nxt  = S_EMIT;
        end else if (stat.den_zero) begin
          status_nxt = ST_ZERO_DEN;
          state_nxt  = S_EMIT;
        end else begin
          cmd.step       = 1'b1;
          cmd.first_step = (cnt_r == '0);
          cnt_nxt        = cnt_r + CNT_W'(1);
          if (cnt_r == LAST_STEP) begin
            status_nxt = ST_OK;
            state_nxt  = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Hold item flags and step count
  always_ff @(posedge clk) begin
    mism_r   <= mism_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/bray_curtis_distance.sv =====
// Top level of the Bray-Curtis distance block.
//
// Usage: drive one element pair per item on in_count_a / in_count_b with the
// end flags; an item is taken at a clock edge with start high and busy low.
// Items that end neither vector leave busy low, so a vector streams at
// one pair per clock. An item with in_end_a or in_end_b set makes busy rise
// for the final quotient: the load state, FRACTION_BITS + 1 steps of the
// restoring divider (one quotient bit per cycle), and the emit state that
// registers the result, so the result strobe out_valid follows the ending
// item after S_LOAD, S_DIV and S_EMIT (S_DIV takes no divide steps on a
// length mismatch or zero denominator). Busy drops in the cycle of the strobe.
// Each result stands on out_distance / out_status for exactly one cycle with
// out_valid high; the receiver cannot stall it. Totals clear once the ending
// item is loaded into the divider.
// Reset (rst_n low, synchronous) clears all totals and returns to idle.
`timescale 1ns / 1ps
`default_nettype none

module bray_curtis_distance #(
  parameter int COUNT_BITS    = bcd_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = bcd_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [COUNT_BITS-1:0]         in_count_a,
  input  wire logic [COUNT_BITS-1:0]         in_count_b,
  input  wire logic                          in_end_a,
  input  wire logic                          in_end_b,
  output logic                               out_valid,
  output logic [bcd_pkg::DIST_W-1:0]         out_distance,
  output logic [bcd_pkg::STATUS_W-1:0]       out_status
);
  import bcd_pkg::*;

  bcd_cmd_t  cmd;
  bcd_stat_t stat;

  bcd_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .end_a (in_end_a),
    .end_b (in_end_b),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bcd_dp #(
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .count_a      (in_count_a),
    .count_b      (in_count_b),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .out_status   (out_status)
  );

  // An ending item always makes the block busy in the next cycle
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_end_a || in_end_b)) |=> busy)
    else $error("ending item did not start the divide sequence");

  // A plain item keeps the block free for the next one
  a_plain_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_end_a && !in_end_b) |=> !busy)
    else $error("non-ending item stalled the input");

  // One strobe per result
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // Error results carry a zero distance
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_distance == '0))
    else $error("error result with nonzero distance");

  // A result only appears when the sequence has just finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

endmodule

`default_nettype wire
